>>> design/sorted_min_priority_queue_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted minimum priority queue
// Clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define SMPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds at any clock edge outside reset.
`define SMPQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SMPQ_ASSERT(lbl, prop, msg)
`define SMPQ_NEVER(lbl, cond, msg)
`endif

`endif

>>> design/smpq_pkg.sv
// ---------------------------------------------------------------------------
// smpq_pkg
// Types and constants shared by the priority queue cells and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int FUNC_W  = 2;
  localparam int ERR_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               ins;    // insert value in sorted position
    logic               del;    // remove head, shift toward head
    logic [VALUE_W-1:0] value;  // value to insert
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> design/sorted_min_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_min_priority_queue
// Sorted-list minimum priority queue of signed Q16.16 values.
// ---------------------------------------------------------------------------
// The queue keeps up to CAPACITY values in ascending order in a chain of
// cells; cell zero always holds the smallest value. Each transfer carries an
// operation: push inserts the value ahead of the first stored value that is
// not smaller (equal values: newest first), pop drops the smallest, clear
// empties the queue, and the unused code reports the state unchanged. Every
// input transfer yields exactly one result transfer with the smallest value
// left (zero when empty), the empty flag, the count (low five bits of the
// fill level) and an error code: pop on an empty queue or push onto a full
// queue is flagged and changes nothing. The block takes one operation per
// clock cycle unless a held result stalls the input: all cells compare the
// pushed value against their entries in parallel and shift or hold in that
// same cycle, so the 32-bit signed compare plus a three-way select in each
// cell sets the path. The result is registered at the input transfer; a new
// input is taken whenever that register is empty or drains at the same edge.
// No clearing pass runs after reset; the queue starts empty.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_min_priority_queue import smpq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [FUNC_W-1:0]  func_i,
  input  wire logic [VALUE_W-1:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [VALUE_W-1:0]      top_value_o,
  output logic                    is_empty_o,
  output logic [COUNT_W-1:0]      count_o,
  output logic [ERR_W-1:0]        error_o
);

  localparam int FILL_W = $clog2(CAPACITY + 1);

  // Fill level and output register.
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] top_q, top_d;
  logic               empty_q, empty_d;
  logic [COUNT_W-1:0] count_q, count_d;
  err_e               err_q, err_d;

  logic       in_xfer;
  func_e      func;
  logic       full, empty;
  cell_ctrl_t ctrl;

  // Chain wiring.
  logic [CAPACITY-1:0]              occ;
  logic [CAPACITY-1:0]              gt;
  logic [CAPACITY-1:0][VALUE_W-1:0] entry;
  logic [CAPACITY-1:0][VALUE_W-1:0] entry_d;

  // Accept when the result register is free or drains at this edge.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign func  = func_e'(func_i);
  assign full  = (fill_q == FILL_W'(CAPACITY));
  assign empty = (fill_q == '0);

  // Decode the operation; rejected push or pop leaves the chain untouched.
  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.value = value_i;
    fill_d     = fill_q;
    err_d      = ERR_NONE;
    if (in_xfer) begin
      case (func)
        FUNC_PUSH: begin
          if (full) begin
            err_d = ERR_FULL;
          end else begin
            ctrl.ins = 1'b1;
            fill_d   = fill_q + FILL_W'(1);
          end
        end
        FUNC_POP: begin
          if (empty) begin
            err_d = ERR_EMPTY;
          end else begin
            ctrl.del = 1'b1;
            fill_d   = fill_q - FILL_W'(1);
          end
        end
        FUNC_CLEAR: fill_d = '0;
        default:    fill_d = fill_q;
      endcase
    end
  end

  // Row of cells: each sees its left and right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               left_gt;
    logic [VALUE_W-1:0] left_entry;
    logic [VALUE_W-1:0] right_entry;

    assign occ[i] = (FILL_W'(i) < fill_q);

    if (i == 0) begin : g_head
      assign left_gt    = 1'b1;
      assign left_entry = '0;
    end else begin : g_body
      assign left_gt    = gt[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_link
      assign right_entry = entry[i+1];
    end

    smpq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ[i]),
      .left_gt_i     (left_gt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .gt_o          (gt[i]),
      .entry_o       (entry[i]),
      .entry_d_o     (entry_d[i])
    );
  end

  // Build the result from the post-operation state of the head cell.
  always_comb begin
    top_d       = (fill_d != '0) ? entry_d[0] : '0;
    empty_d     = (fill_d == '0);
    count_d     = COUNT_W'(fill_d);
    out_valid_d = in_xfer || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: load on every input transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      top_q   <= top_d;
      empty_q <= empty_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = top_q;
  assign is_empty_o  = empty_q;
  assign count_o     = count_q;
  assign error_o     = err_q;

`include "sorted_min_priority_queue_assert.svh"

  `SMPQ_NEVER(a_fill_range, fill_q > FILL_W'(CAPACITY), "fill level above capacity")
  `SMPQ_ASSERT(a_result_follows, in_xfer |=> out_valid_o, "no result after input transfer")
  `SMPQ_ASSERT(a_empty_err, out_valid_o && (err_q == ERR_EMPTY) |-> is_empty_o, "empty pop left queue nonempty")
  `SMPQ_ASSERT(a_empty_top, out_valid_o && is_empty_o |-> (top_value_o == '0), "empty queue reports nonzero top")
  `SMPQ_ASSERT(a_full_hold, in_xfer && full && (func == FUNC_PUSH) |=> fill_q == $past(fill_q), "push on full queue changed fill")

endmodule

`default_nettype wire

>>> design/smpq_cell.sv
// ---------------------------------------------------------------------------
// smpq_cell
// One storage slot of the sorted chain: compare, then keep, insert or shift.
// ---------------------------------------------------------------------------
`default_nettype none

module smpq_cell import smpq_pkg::*; (
  input  wire logic               clk_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic               occ_i,          // slot holds a live value
  input  wire logic               left_gt_i,      // left neighbor keeps its value
  input  wire logic [VALUE_W-1:0] left_entry_i,
  input  wire logic [VALUE_W-1:0] right_entry_i,
  output logic                    gt_o,           // this slot keeps its value
  output logic [VALUE_W-1:0]      entry_o,
  output logic [VALUE_W-1:0]      entry_d_o
);

  logic [VALUE_W-1:0] entry_q, entry_d;

  // Live entries smaller than the new value stay in place.
  assign gt_o = occ_i && ($signed(ctrl_i.value) > $signed(entry_q));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (gt_o) begin
        entry_d = entry_q;
      end else if (left_gt_i) begin
        entry_d = ctrl_i.value;
      end else begin
        entry_d = left_entry_i;
      end
    end else if (ctrl_i.del) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

`default_nettype wire
